// File: rtl/pidc_pkg.sv
// Shared constants, register codes, sequencer states and command types for the PID block.
package pidc_pkg;

    // Fixed-point format of the gains and time base
    localparam int GAIN_FRAC_BITS = 8;
    localparam int TICKS_PER_SEC  = 10000;
    localparam int LIMIT          = 30;

    // Field widths
    localparam int MEAS_W = 16;
    localparam int GAIN_W = 16;
    localparam int TICK_W = 16;
    localparam int OUT_W  = 6;
    localparam int ERR_W  = MEAS_W + 1;
    localparam int DERR_W = ERR_W + 1;

    // Datapath widths
    localparam int ACC_W    = 50;
    localparam int MB_W     = TICK_W + 1;
    localparam int LEN_W    = $clog2(MB_W + 1);
    localparam int TPS_LEN  = $clog2(TICKS_PER_SEC) + 1;
    localparam int SCALE_W  = TICK_W + GAIN_FRAC_BITS;
    localparam int PROD_T_W = ERR_W + TICK_W + 1;
    localparam int DV_W     = SCALE_W + OUT_W;
    localparam int STEP_W   = $clog2(OUT_W + 1);

    // Derived constants
    localparam int ONE = 1 << GAIN_FRAC_BITS;
    localparam int DEN = TICKS_PER_SEC << GAIN_FRAC_BITS;

    // Configuration register codes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_MUL_NUM,
        ST_MUL_INT,
        ST_DIV_INT,
        ST_MUL_DERR,
        ST_MUL_DER,
        ST_MUL_PROP,
        ST_MUL_SCALE,
        ST_DIV_OUT,
        ST_DONE
    } state_t;

    // Command to the serial multiply-accumulate unit
    typedef struct packed {
        logic             start;
        logic             clear;
        logic [LEN_W-1:0] len;
    } mac_cmd_t;

endpackage

// File: rtl/pidc_mac.sv
// Serial-parallel multiply-accumulate unit: one multiplier bit per cycle.
module pidc_mac (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pidc_pkg::mac_cmd_t               cmd,
    input  logic signed [pidc_pkg::ACC_W-1:0] a,
    input  logic [pidc_pkg::MB_W-1:0]        b,
    output logic                             done,
    output logic signed [pidc_pkg::ACC_W-1:0] acc
);

    logic                              busy_reg;
    logic [pidc_pkg::LEN_W-1:0]        cnt_reg;
    logic signed [pidc_pkg::ACC_W-1:0] a_reg;
    logic [pidc_pkg::MB_W-1:0]         b_reg;
    logic signed [pidc_pkg::ACC_W-1:0] acc_reg;
    logic                              last;
    logic signed [pidc_pkg::ACC_W-1:0] addend;

    // Top multiplier bit carries negative weight
    assign last   = (cnt_reg == pidc_pkg::LEN_W'(1));
    assign addend = last ? -a_reg : a_reg;
    assign done   = busy_reg && last;
    assign acc    = acc_reg;

    // Control: run for len steps after a start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= cmd.len;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - pidc_pkg::LEN_W'(1);
            if (last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: shift multiplicand up, multiplier down, add on each set bit
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            a_reg <= a;
            b_reg <= b;
            if (cmd.clear) begin
                acc_reg <= '0;
            end
        end else if (busy_reg) begin
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
            if (b_reg[0]) begin
                acc_reg <= acc_reg + addend;
            end
        end
    end

endmodule

// File: rtl/pidc_div.sv
// Restoring divider with truncation toward zero and saturation to the output limit.
module pidc_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [pidc_pkg::ACC_W-1:0] dividend,
    input  logic [pidc_pkg::SCALE_W-1:0]      divisor,
    output logic                              done,
    output logic signed [pidc_pkg::OUT_W-1:0] quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [pidc_pkg::STEP_W-1:0]       step_reg;
    logic [pidc_pkg::ACC_W-2:0]        rem_reg;
    logic [pidc_pkg::DV_W-1:0]         dv_reg;
    logic [pidc_pkg::OUT_W-1:0]        q_reg;
    logic                              ovf_reg;
    logic                              neg_reg;
    logic signed [pidc_pkg::ACC_W-1:0] dividend_neg;
    logic [pidc_pkg::ACC_W-2:0]        dividend_mag;
    logic [pidc_pkg::ACC_W-2:0]        dv_ext;
    logic                              ge;
    logic                              last;
    logic [pidc_pkg::OUT_W-1:0]        mag;

    // Magnitude of the dividend
    assign dividend_neg = -dividend;
    assign dividend_mag = dividend[pidc_pkg::ACC_W-1] ? dividend_neg[pidc_pkg::ACC_W-2:0]
                                                       : dividend[pidc_pkg::ACC_W-2:0];

    assign dv_ext = (pidc_pkg::ACC_W-1)'(dv_reg);
    assign ge     = (rem_reg >= dv_ext);
    assign last   = (step_reg == pidc_pkg::STEP_W'(pidc_pkg::OUT_W));

    // Saturate, then restore the sign
    always_comb begin
        if (ovf_reg || (q_reg > pidc_pkg::OUT_W'(pidc_pkg::LIMIT))) begin
            mag = pidc_pkg::OUT_W'(pidc_pkg::LIMIT);
        end else begin
            mag = q_reg;
        end
    end

    assign quotient = neg_reg ? signed'(-mag) : signed'(mag);
    assign done     = done_reg;

    // Control: first step checks overflow, then one quotient bit per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + pidc_pkg::STEP_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare, subtract and shift the divisor down
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend_mag;
            dv_reg  <= pidc_pkg::DV_W'(divisor) << pidc_pkg::OUT_W;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= dividend[pidc_pkg::ACC_W-1];
        end else if (busy_reg) begin
            dv_reg <= dv_reg >> 1;
            if (step_reg == '0) begin
                ovf_reg <= ge;
            end else begin
                q_reg <= {q_reg[pidc_pkg::OUT_W-2:0], ge};
                if (ge) begin
                    rem_reg <= rem_reg - dv_ext;
                end
            end
        end
    end

endmodule

// File: rtl/pid_correction_clamped.sv
// Top level of the PID correction step: handshakes, gain registers, state and sequencer.
//
// Each accepted beat yields one clamped correction. The next beat is accepted only once the
// sequencer has finished the current item. Its run time is set by the single serial
// multiply-accumulate unit, which retires one multiplier bit per cycle over seven products
// (17, 16, 6, 15, 16, 16 and 6 bits) when the tick count is nonzero and over the last two
// when it is zero, and by the restoring divider, which runs twice, or once when the tick
// count is zero. The finished result waits in an output register, so the next beat is
// taken while it is still pending. Gains are signed Q8.8; write them only while no item is
// in flight. Writes to index 3 are ignored.
module pid_correction_clamped (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [pidc_pkg::MEAS_W-1:0]    s_measured,
    input  logic signed [pidc_pkg::MEAS_W-1:0]    s_target,
    input  logic [pidc_pkg::TICK_W-1:0]           s_elapsed_ticks,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pidc_pkg::OUT_W-1:0]     m_drive_correction,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic signed [pidc_pkg::GAIN_W-1:0]    cfg_data
);

    pidc_pkg::state_t                      state_reg;
    pidc_pkg::state_t                      state_next;
    logic                                  launched_reg;
    logic                                  launched_next;

    logic signed [pidc_pkg::GAIN_W-1:0]    kp_reg;
    logic signed [pidc_pkg::GAIN_W-1:0]    ki_reg;
    logic signed [pidc_pkg::GAIN_W-1:0]    kd_reg;

    logic signed [pidc_pkg::ERR_W-1:0]     err_reg;
    logic [pidc_pkg::TICK_W-1:0]           ticks_reg;
    logic signed [pidc_pkg::PROD_T_W-1:0]  t_reg;
    logic signed [pidc_pkg::OUT_W-1:0]     integ_reg;
    logic signed [pidc_pkg::ERR_W-1:0]     prev_err_reg;
    logic                                  m_valid_reg;
    logic signed [pidc_pkg::OUT_W-1:0]     drive_reg;

    logic                                  ticks_zero;
    logic [pidc_pkg::SCALE_W-1:0]          scale;
    logic signed [pidc_pkg::DERR_W-1:0]    derr;

    pidc_pkg::mac_cmd_t                    mac_cmd;
    logic signed [pidc_pkg::ACC_W-1:0]     mac_a;
    logic [pidc_pkg::MB_W-1:0]             mac_b;
    logic                                  mac_done;
    logic signed [pidc_pkg::ACC_W-1:0]     mac_acc;

    logic                                  div_start;
    logic [pidc_pkg::SCALE_W-1:0]          div_divisor;
    logic                                  div_done;
    logic signed [pidc_pkg::OUT_W-1:0]     div_quot;

    logic                                  in_take;
    logic                                  t_load;
    logic                                  integ_load;
    logic                                  out_load;

    // Per-item scale: the tick count in gain units, or one when no time has passed
    assign ticks_zero = (ticks_reg == '0);
    assign scale      = ticks_zero ? pidc_pkg::SCALE_W'(pidc_pkg::ONE)
                                   : pidc_pkg::SCALE_W'(ticks_reg) << pidc_pkg::GAIN_FRAC_BITS;
    assign derr       = pidc_pkg::DERR_W'(err_reg) - pidc_pkg::DERR_W'(prev_err_reg);

    assign cfg_ready          = aresetn;
    assign m_valid            = m_valid_reg;
    assign m_drive_correction = drive_reg;

    pidc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .a       (mac_a),
        .b       (mac_b),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    pidc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mac_acc),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer: launch each operation once, advance on its completion
    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        mac_cmd       = '0;
        mac_a         = '0;
        mac_b         = '0;
        div_start     = 1'b0;
        div_divisor   = scale;
        s_ready       = 1'b0;
        in_take       = 1'b0;
        t_load        = 1'b0;
        integ_load    = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            pidc_pkg::ST_IDLE: begin
                s_ready       = aresetn;
                launched_next = 1'b0;
                if (s_valid && aresetn) begin
                    in_take    = 1'b1;
                    state_next = (s_elapsed_ticks == '0) ? pidc_pkg::ST_MUL_PROP
                                                         : pidc_pkg::ST_MUL_T;
                end
            end
            // err * ticks
            pidc_pkg::ST_MUL_T: begin
                mac_a = pidc_pkg::ACC_W'(err_reg);
                mac_b = {1'b0, ticks_reg};
                if (!launched_reg) begin
                    mac_cmd       = '{start: 1'b1, clear: 1'b1,
                                      len: pidc_pkg::LEN_W'(pidc_pkg::MB_W)};
                    launched_next = 1'b1;
                end else if (mac_done) begin
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_MUL_NUM;
                end
            end
            // err * ticks * integ_gain; hold the first product for the output sum
            pidc_pkg::ST_MUL_NUM: begin
                mac_a = mac_acc;
                mac_b = pidc_pkg::MB_W'(ki_reg);
                if (!launched_reg) begin
                    mac_cmd       = '{start: 1'b1, clear: 1'b1,
                                      len: pidc_pkg::LEN_W'(pidc_pkg::GAIN_W)};
                    t_load        = 1'b1;
                    launched_next = 1'b1;
                end else if (mac_done) begin
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_MUL_INT;
                end
            end
            // plus integral * denominator
            pidc_pkg::ST_MUL_INT: begin
                mac_a = pidc_pkg::ACC_W'(pidc_pkg::DEN);
                mac_b = pidc_pkg::MB_W'(integ_reg);
                if (!launched_reg) begin
                    mac_cmd       = '{start: 1'b1, clear: 1'b0,
                                      len: pidc_pkg::LEN_W'(pidc_pkg::OUT_W)};
                    launched_next = 1'b1;
                end else if (mac_done) begin
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_DIV_INT;
                end
            end
            // new integral = clamp(num / denominator)
            pidc_pkg::ST_DIV_INT: begin
                div_divisor = pidc_pkg::SCALE_W'(pidc_pkg::DEN);
                if (!launched_reg) begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end else if (div_done) begin
                    integ_load    = 1'b1;
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_MUL_DERR;
                end
            end
            // error difference * ticks per second
            pidc_pkg::ST_MUL_DERR: begin
                mac_a = pidc_pkg::ACC_W'(derr);
                mac_b = pidc_pkg::MB_W'(pidc_pkg::TICKS_PER_SEC);
                if (!launched_reg) begin
                    mac_cmd       = '{start: 1'b1, clear: 1'b1,
                                      len: pidc_pkg::LEN_W'(pidc_pkg::TPS_LEN)};
                    launched_next = 1'b1;
                end else if (mac_done) begin
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_MUL_DER;
                end
            end
            // times deriv_gain
            pidc_pkg::ST_MUL_DER: begin
                mac_a = mac_acc;
                mac_b = pidc_pkg::MB_W'(kd_reg);
                if (!launched_reg) begin
                    mac_cmd       = '{start: 1'b1, clear: 1'b1,
                                      len: pidc_pkg::LEN_W'(pidc_pkg::GAIN_W)};
                    launched_next = 1'b1;
                end else if (mac_done) begin
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_MUL_PROP;
                end
            end
            // proportional term; starts the sum when no time has passed
            pidc_pkg::ST_MUL_PROP: begin
                mac_a = ticks_zero ? pidc_pkg::ACC_W'(err_reg) : pidc_pkg::ACC_W'(t_reg);
                mac_b = pidc_pkg::MB_W'(kp_reg);
                if (!launched_reg) begin
                    mac_cmd       = '{start: 1'b1, clear: ticks_zero,
                                      len: pidc_pkg::LEN_W'(pidc_pkg::GAIN_W)};
                    launched_next = 1'b1;
                end else if (mac_done) begin
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_MUL_SCALE;
                end
            end
            // plus integral * scale
            pidc_pkg::ST_MUL_SCALE: begin
                mac_a = pidc_pkg::ACC_W'(scale);
                mac_b = pidc_pkg::MB_W'(integ_reg);
                if (!launched_reg) begin
                    mac_cmd       = '{start: 1'b1, clear: 1'b0,
                                      len: pidc_pkg::LEN_W'(pidc_pkg::OUT_W)};
                    launched_next = 1'b1;
                end else if (mac_done) begin
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_DIV_OUT;
                end
            end
            // correction = clamp(sum / scale)
            pidc_pkg::ST_DIV_OUT: begin
                if (!launched_reg) begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end else if (div_done) begin
                    launched_next = 1'b0;
                    state_next    = pidc_pkg::ST_DONE;
                end
            end
            // hand the result to the output register once it is free
            pidc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = pidc_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Control and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pidc_pkg::ST_IDLE;
            launched_reg <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
            m_valid_reg  <= 1'b0;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            if (integ_load) begin
                integ_reg <= div_quot;
            end
            if (out_load) begin
                prev_err_reg <= err_reg;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Gain register writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    pidc_pkg::REG_PROP_GAIN:  kp_reg <= cfg_data;
                    pidc_pkg::REG_INTEG_GAIN: ki_reg <= cfg_data;
                    pidc_pkg::REG_DERIV_GAIN: kd_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (in_take) begin
            err_reg   <= pidc_pkg::ERR_W'(s_target) - pidc_pkg::ERR_W'(s_measured);
            ticks_reg <= s_elapsed_ticks;
        end
        if (t_load) begin
            t_reg <= mac_acc[pidc_pkg::PROD_T_W-1:0];
        end
        if (out_load) begin
            drive_reg <= div_quot;
        end
    end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the PID correction step with clamped integral and output.
module testbench;

    localparam logic [pidc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // unmapped index, writes dropped
    localparam int PHASES         = 12;
    localparam int STEPS_PER_GAIN = 153;
    localparam int SETTLE_CYCLES  = 150;

    typedef struct packed {
        logic signed [pidc_pkg::MEAS_W-1:0] measured;
        logic signed [pidc_pkg::MEAS_W-1:0] target;
        logic [pidc_pkg::TICK_W-1:0]        ticks;
    } pid_sample_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_valid = 1'b0;
    logic                                  s_ready;
    logic signed [pidc_pkg::MEAS_W-1:0]    s_measured = '0;
    logic signed [pidc_pkg::MEAS_W-1:0]    s_target = '0;
    logic [pidc_pkg::TICK_W-1:0]           s_elapsed_ticks = '0;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic signed [pidc_pkg::OUT_W-1:0]     m_drive_correction;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic signed [pidc_pkg::GAIN_W-1:0]    cfg_data = '0;

    // Local copy of the gains and the controller state
    logic signed [pidc_pkg::GAIN_W-1:0]    kp_set = '0;
    logic signed [pidc_pkg::GAIN_W-1:0]    ki_set = '0;
    logic signed [pidc_pkg::GAIN_W-1:0]    kd_set = '0;
    logic signed [pidc_pkg::OUT_W-1:0]     integ_state = '0;
    logic signed [pidc_pkg::ERR_W-1:0]     prev_err = '0;

    pid_sample_t                           samples_to_send[$];
    logic signed [pidc_pkg::OUT_W-1:0]     corrections_due[$];
    pid_sample_t                           outgoing;
    pid_sample_t                           accepted;
    logic                                  s_fire = 1'b0;
    int                                    send_idle_pct = 7;
    int                                    recv_idle_pct = 49;
    int                                    mismatches = 0;
    int                                    steps_taken = 0;
    int                                    zero_tick_steps = 0;
    int                                    saturated = 0;
    int                                    results_checked = 0;
    int                                    gain_sets = 0;

    pid_correction_clamped dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_measured         (s_measured),
        .s_target           (s_target),
        .s_elapsed_ticks    (s_elapsed_ticks),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_drive_correction (m_drive_correction),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic longint clamp_limit(input longint v);
        if (v > pidc_pkg::LIMIT) return pidc_pkg::LIMIT;
        if (v < -pidc_pkg::LIMIT) return -pidc_pkg::LIMIT;
        return v;
    endfunction

    // Advance the controller state by one step and return the clamped correction
    function automatic logic signed [pidc_pkg::OUT_W-1:0] next_correction(input pid_sample_t smp);
        longint meas, tgt, ticks, err, derr, integ, unit, num, den, total;
        longint kp, ki, kd;
        meas  = smp.measured;
        tgt   = smp.target;
        ticks = smp.ticks;
        kp    = kp_set;
        ki    = ki_set;
        kd    = kd_set;
        integ = integ_state;
        err   = tgt - meas;
        unit  = longint'(1) << pidc_pkg::GAIN_FRAC_BITS;
        if (ticks != 0) begin
            den   = longint'(pidc_pkg::TICKS_PER_SEC) * unit;
            num   = integ * den + err * ticks * ki;
            integ = clamp_limit(num / den);
            derr  = err - longint'(prev_err);
            den   = unit * ticks;
            num   = err * kp * ticks + integ * unit * ticks
                  + derr * longint'(pidc_pkg::TICKS_PER_SEC) * kd;
            total = clamp_limit(num / den);
        end else begin
            // no time elapsed: hold the integral, drop the derivative
            total = clamp_limit((err * kp + integ * unit) / unit);
        end
        integ_state = integ[pidc_pkg::OUT_W-1:0];
        prev_err    = err[pidc_pkg::ERR_W-1:0];
        return total[pidc_pkg::OUT_W-1:0];
    endfunction

    function automatic pid_sample_t random_sample();
        pid_sample_t smp;
        int          base, pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: any value in every field
            smp.measured = pidc_pkg::MEAS_W'($urandom());
            smp.target   = pidc_pkg::MEAS_W'($urandom());
            smp.ticks    = pidc_pkg::TICK_W'($urandom());
        end else begin
            // near-setpoint operation, mostly with a moderate step time
            base = int'($urandom_range(60000)) - 30000;
            smp.measured = pidc_pkg::MEAS_W'(base);
            smp.target   = pidc_pkg::MEAS_W'(base + int'($urandom_range(80)) - 40);
            pick = $urandom_range(99);
            if (pick < 8) smp.ticks = '0;
            else if (pick < 11) smp.ticks = {pidc_pkg::TICK_W{1'b1}};
            else if (pick < 15) smp.ticks = pidc_pkg::TICK_W'($urandom());
            else smp.ticks = pidc_pkg::TICK_W'($urandom_range(3000, 1));
        end
        return smp;
    endfunction

    function automatic logic signed [pidc_pkg::GAIN_W-1:0] random_gain();
        if ($urandom_range(99) < 70)
            return pidc_pkg::GAIN_W'(int'($urandom_range(1536)) - 768);
        return pidc_pkg::GAIN_W'($urandom());
    endfunction

    task automatic queue_sample(input int meas, input int tgt, input int ticks);
        pid_sample_t smp;
        smp.measured = meas[pidc_pkg::MEAS_W-1:0];
        smp.target   = tgt[pidc_pkg::MEAS_W-1:0];
        smp.ticks    = ticks[pidc_pkg::TICK_W-1:0];
        samples_to_send.push_back(smp);
    endtask

    task automatic write_gain(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [pidc_pkg::GAIN_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_valid || corrections_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Input driver: present the next sample once the previous beat is gone; also drive m_ready at random
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                outgoing = samples_to_send.pop_front();
                s_valid         <= 1'b1;
                s_measured      <= outgoing.measured;
                s_target        <= outgoing.target;
                s_elapsed_ticks <= outgoing.ticks;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: track gain writes, predict on each input beat, check each result beat
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    pidc_pkg::REG_PROP_GAIN:  kp_set = cfg_data;
                    pidc_pkg::REG_INTEG_GAIN: ki_set = cfg_data;
                    pidc_pkg::REG_DERIV_GAIN: kd_set = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                accepted.measured = s_measured;
                accepted.target   = s_target;
                accepted.ticks    = s_elapsed_ticks;
                corrections_due.push_back(next_correction(accepted));
                steps_taken++;
                if (s_elapsed_ticks == '0) zero_tick_steps++;
            end
            if (m_valid && m_ready) begin
                if (corrections_due.size() == 0) begin
                    report_mismatch($sformatf("correction %0d with no step pending",
                                              m_drive_correction));
                end else begin
                    logic signed [pidc_pkg::OUT_W-1:0] want;
                    want = corrections_due.pop_front();
                    results_checked++;
                    if (want == pidc_pkg::LIMIT || want == -pidc_pkg::LIMIT) saturated++;
                    if (m_drive_correction !== want)
                        report_mismatch($sformatf("drive_correction got %0d want %0d",
                                                  m_drive_correction, want));
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Gains still at reset: every correction comes out as zero
        queue_sample(100, -100, 50);
        queue_sample(-32768, 32767, 0);
        wait_drained();

        // Directed steps at unit P, I of ten per second, small D
        write_gain(pidc_pkg::REG_PROP_GAIN, 16'sd256);
        write_gain(pidc_pkg::REG_INTEG_GAIN, 16'sd2560);
        write_gain(pidc_pkg::REG_DERIV_GAIN, 16'sd26);
        write_gain(REG_SPARE, 16'h7fff);
        gain_sets++;
        queue_sample(0, 0, 0);
        queue_sample(0, 5, 0);
        queue_sample(0, 5, 100);
        queue_sample(0, 5, 10000);
        queue_sample(3, 0, 1);
        queue_sample(-32768, 32767, 65535);
        queue_sample(-32768, 32767, 0);
        queue_sample(32767, -32768, 65535);
        queue_sample(32767, -32768, 1);
        queue_sample(32767, -32768, 0);
        queue_sample(-1, -1, 65535);
        queue_sample(100, 90, 500);
        queue_sample(100, 110, 500);
        queue_sample(-20000, -20004, 2000);
        queue_sample(-20000, -20004, 2000);
        queue_sample(12345, 12345, 0);
        queue_sample(0, 0, 1);
        wait_drained();

        // Random phases: new gains each phase, idling pattern per third of the run
        for (int p = 0; p < PHASES; p++) begin
            logic signed [pidc_pkg::GAIN_W-1:0] kp, ki, kd;
            case (p / 4)
                0: begin send_idle_pct = 7;  recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (p)
                0: begin kp = 16'sh8000; ki = 16'sh8000; kd = 16'sh8000; end
                1: begin kp = 16'sh7fff; ki = 16'sh7fff; kd = 16'sh7fff; end
                2: begin kp = '0; ki = '0; kd = '0; end
                default: begin kp = random_gain(); ki = random_gain(); kd = random_gain(); end
            endcase
            write_gain(pidc_pkg::REG_PROP_GAIN, kp);
            write_gain(pidc_pkg::REG_INTEG_GAIN, ki);
            write_gain(pidc_pkg::REG_DERIV_GAIN, kd);
            if (p % 2 == 1) write_gain(REG_SPARE, pidc_pkg::GAIN_W'($urandom()));
            gain_sets++;
            for (int i = 0; i < STEPS_PER_GAIN; i++) samples_to_send.push_back(random_sample());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Ran %0d PID steps (%0d with zero ticks) over %0d gain settings.",
                 steps_taken, zero_tick_steps, gain_sets);
        $display("Checked %0d corrections, %0d at the clamp limit, %0d mismatches.",
                 results_checked, saturated, mismatches);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
